// ----- sv/vrp_pkg.sv -----
// vrp_pkg: shared types, codes and tables for the vertex rotate and project block
`timescale 1ns / 1ps

package vrp_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COPY,
      ST_ANG_ABS,
      ST_ANG_Q100,
      ST_ANG_Q360,
      ST_ANG_REM,
      ST_ANG_LUT,
      ST_MIX,
      ST_PX_LOAD,
      ST_PX_DIV,
      ST_PY_LOAD,
      ST_PY_DIV,
      ST_EMIT
   } state_type;

   localparam logic [1:0] ACT_REFRESH = 2'd0;
   localparam logic [1:0] ACT_TAP     = 2'd1;
   localparam logic [1:0] ACT_LOAD    = 2'd2;
   localparam logic [1:0] ACT_NOP     = 2'd3;

   localparam logic [1:0] CSR_COS_A = 2'd0;
   localparam logic [1:0] CSR_SIN_A = 2'd1;
   localparam logic [1:0] CSR_COS_B = 2'd2;
   localparam logic [1:0] CSR_SIN_B = 2'd3;

   localparam logic signed [15:0] RST_COS = 16'sd32758;
   localparam logic signed [15:0] RST_SIN = 16'sd572;

   localparam int DIV_STEPS  = 12;
   localparam int MAX_POINTS = 8;
   localparam logic signed [18:0] Z_OFFSET = 19'sd49152;

   // ceil(2^26 / 100) and ceil(2^20 / 360)
   localparam logic [19:0] RECIP_100 = 20'd671089;
   localparam logic [11:0] RECIP_360 = 12'd2913;

   localparam logic [15:0] QUARTER_SINE [0:90] = '{
      16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
      16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
      16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
      16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14364, 16'd14876,
      16'd15383, 16'd15886, 16'd16383, 16'd16876, 16'd17364, 16'd17846, 16'd18323,
      16'd18794, 16'd19260, 16'd19720, 16'd20173, 16'd20621, 16'd21062, 16'd21497,
      16'd21925, 16'd22347, 16'd22762, 16'd23170, 16'd23571, 16'd23964, 16'd24351,
      16'd24730, 16'd25101, 16'd25465, 16'd25821, 16'd26169, 16'd26509, 16'd26841,
      16'd27165, 16'd27481, 16'd27788, 16'd28087, 16'd28377, 16'd28659, 16'd28932,
      16'd29196, 16'd29451, 16'd29697, 16'd29934, 16'd30162, 16'd30381, 16'd30591,
      16'd30791, 16'd30982, 16'd31163, 16'd31335, 16'd31498, 16'd31650, 16'd31794,
      16'd31927, 16'd32051, 16'd32165, 16'd32269, 16'd32364, 16'd32448, 16'd32523,
      16'd32587, 16'd32642, 16'd32687, 16'd32722, 16'd32747, 16'd32762, 16'd32767
   };

   // sine of an angle in 0..359 degrees through the folded quarter table
   function automatic logic signed [15:0] sine_fold(input logic [8:0] r);
      logic [6:0]  idx;
      logic        neg;
      logic [15:0] mag;
      if (r < 9'd90) begin
         idx = 7'(r);
         neg = 1'b0;
      end else if (r < 9'd180) begin
         idx = 7'(9'd180 - r);
         neg = 1'b0;
      end else if (r < 9'd270) begin
         idx = 7'(r - 9'd180);
         neg = 1'b1;
      end else begin
         idx = 7'(9'd360 - r);
         neg = 1'b1;
      end
      mag = QUARTER_SINE[idx];
      return neg ? -$signed(mag) : $signed(mag);
   endfunction

endpackage

// ----- sv/vrp_if.sv -----
// vrp_if: request, response and register write channels
`timescale 1ns / 1ps

interface vrp_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [15:0] tilt_x;
   logic signed [15:0] tilt_y;
   logic [2:0]         load_index;
   logic signed [15:0] load_x;
   logic signed [15:0] load_y;
   logic signed [15:0] load_z;

   modport source (output valid, action, tilt_x, tilt_y, load_index, load_x, load_y,
                   load_z, input ready);
   modport sink (input valid, action, tilt_x, tilt_y, load_index, load_x, load_y,
                 load_z, output ready);
endinterface

interface vrp_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         point_index;
   logic signed [9:0]  screen_x;
   logic signed [9:0]  screen_y;
   logic               last_point;

   modport source (output valid, point_index, screen_x, screen_y, last_point,
                   input ready);
   modport sink (input valid, point_index, screen_x, screen_y, last_point,
                 output ready);
endinterface

interface vrp_csr_if;
   logic               valid;
   logic               ready;
   logic [1:0]         index;
   logic signed [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/vertex_rotate_project.sv -----
// vertex_rotate_project: rotation and perspective projection of a small vertex set
//
//  channel    dir  word
//  req_port   in   action, tilt_x, tilt_y, load_index, load_x, load_y, load_z
//  rsp_port   out  point_index, screen_x, screen_y, last_point
//  csr_port   in   index, data (spin sine/cosine pairs), always ready
//
// load and tap finish in idle; a tap that leaves free mode runs the copy sweep
// refresh: 4 angles by reciprocal multiplies, then the mix steps per vertex on the shared
// multiplier, plus two divisions per emitted point on the 12-step divider
// req ready only in idle; a point waits in the output register while rsp is stalled
// synchronous reset clears mode, registers and current vertices
`timescale 1ns / 1ps

module vertex_rotate_project #(
   parameter int NUM_VERTICES  = 8,
   parameter int SCREEN_WIDTH  = 240,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic       clock,
   input  logic       reset,
   vrp_req_if.sink    req_port,
   vrp_rsp_if.source  rsp_port,
   vrp_csr_if.sink    csr_port
);

   localparam int VW         = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
   localparam int EMIT_COUNT = (NUM_VERTICES < vrp_pkg::MAX_POINTS) ? NUM_VERTICES
                                                                     : vrp_pkg::MAX_POINTS;
   localparam logic signed [12:0] HALF_W = 13'(SCREEN_WIDTH / 2);
   localparam logic signed [12:0] HALF_H = 13'(SCREEN_HEIGHT / 2);
   localparam logic signed [16:0] SIZE_W = 17'(SCREEN_WIDTH);
   localparam logic signed [16:0] SIZE_H = 17'(SCREEN_HEIGHT);

   function automatic logic signed [15:0] round_sat(input logic signed [34:0] s);
      logic signed [34:0] t;
      logic signed [19:0] q;
      t = s + 35'sd16384;
      q = 20'(t >>> 15);
      if (q > 20'sd32767) return 16'sh7fff;
      if (q < -20'sd32768) return 16'sh8000;
      return 16'(q);
   endfunction

   function automatic logic signed [9:0] screen_sat(input logic signed [12:0] p);
      if (p > 13'sd511) return 10'sd511;
      if (p < -13'sd512) return -10'sd512;
      return 10'(p);
   endfunction

   vrp_pkg::state_type state_ff, state_in;
   logic [VW-1:0]      vtx_ff, vtx_in;
   logic [2:0]         step_ff, step_in;
   logic [1:0]         ang_ff, ang_in;
   logic signed [15:0] tx_ff, tx_in, ty_ff, ty_in;
   logic signed [15:0] sine_ff [0:3];
   logic signed [15:0] sine_in;
   logic               sine_we;
   logic signed [33:0] acc_ff, acc_in;
   logic signed [15:0] m0_ff, m0_in, m1_ff, m1_in, m2_ff, m2_in;
   logic signed [9:0]  sx_ff, sx_in;
   logic               ang_neg_ff, ang_neg_in;
   logic [18:0]        ang_mag_ff, ang_mag_in;
   logic [11:0]        ang_q_ff, ang_q_in;
   logic [3:0]         ang_k_ff, ang_k_in;
   logic [8:0]         ang_rem_ff, ang_rem_in;
   logic               free_ff, free_in;
   logic signed [15:0] cos_a_ff, sin_a_ff, cos_b_ff, sin_b_ff;

   logic [29:0]        div_rem_ff, div_ds_ff;
   logic [11:0]        div_q_ff;
   logic [3:0]         div_cnt_ff;
   logic               div_neg_ff;
   logic               div_load, div_step;
   logic [26:0]        div_mag;
   logic               div_negv;
   logic [17:0]        div_d;

   logic               out_valid_ff, out_valid_in;
   logic [2:0]         out_idx_ff, out_idx_in;
   logic signed [9:0]  out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic               out_last_ff, out_last_in;

   logic signed [15:0] orig_x [0:NUM_VERTICES-1];
   logic signed [15:0] orig_y [0:NUM_VERTICES-1];
   logic signed [15:0] orig_z [0:NUM_VERTICES-1];
   logic signed [15:0] cur_x_ff [0:NUM_VERTICES-1];
   logic signed [15:0] cur_y_ff [0:NUM_VERTICES-1];
   logic signed [15:0] cur_z_ff [0:NUM_VERTICES-1];
   logic               copy_we, mix_we, load_we;
   logic signed [15:0] wb_x, wb_y, wb_z;

   logic               req_acc;
   logic signed [16:0] mul_a, mul_b;
   logic signed [33:0] prod;
   logic signed [34:0] sum;
   logic signed [15:0] rnd;
   logic signed [20:0] ang_num;
   logic signed [33:0] prod_mag_s;
   logic signed [18:0] zs;
   logic [17:0]        zdiv;
   logic signed [12:0] qs;
   logic [11:0]        q100;
   logic [3:0]         q360;
   logic [8:0]         rdeg;
   logic               out_free, last_vtx;
   logic signed [15:0] cp, cq, cr, fc, fs, fc2, fs2;

   assign req_port.ready    = (state_ff == vrp_pkg::ST_IDLE);
   assign req_acc           = req_port.valid && req_port.ready;
   assign csr_port.ready    = 1'b1;
   assign rsp_port.valid       = out_valid_ff;
   assign rsp_port.point_index = out_idx_ff;
   assign rsp_port.screen_x    = out_x_ff;
   assign rsp_port.screen_y    = out_y_ff;
   assign rsp_port.last_point  = out_last_ff;
   assign out_free = !out_valid_ff || rsp_port.ready;
   assign last_vtx = (32'(vtx_ff) == NUM_VERTICES - 1);

   // rotation operands: free mode spins current, tilt mode rotates originals
   always_comb begin
      if (free_ff) begin
         cp  = cur_x_ff[vtx_ff];
         cq  = cur_z_ff[vtx_ff];
         cr  = cur_y_ff[vtx_ff];
         fc  = cos_a_ff;
         fs  = sin_a_ff;
         fc2 = cos_b_ff;
         fs2 = sin_b_ff;
      end else begin
         cp  = orig_y[vtx_ff];
         cq  = orig_z[vtx_ff];
         cr  = orig_x[vtx_ff];
         fc  = sine_ff[3];
         fs  = sine_ff[2];
         fc2 = sine_ff[1];
         fs2 = sine_ff[0];
      end
   end

   always_comb begin
      unique case (ang_ff)
         2'd0:    ang_num = -(21'(tx_ff) * 21'sd9);
         2'd1:    ang_num = 21'sd9000 - 21'(tx_ff) * 21'sd9;
         2'd2:    ang_num = 21'(ty_ff) * 21'sd9;
         default: ang_num = 21'sd9000 + 21'(ty_ff) * 21'sd9;
      endcase
   end

   assign prod = mul_a * mul_b;
   assign sum  = 35'(acc_ff) + 35'(prod);
   assign rnd  = round_sat(sum);
   assign prod_mag_s = prod[33] ? -prod : prod;
   assign zs   = 19'(cur_z_ff[vtx_ff]) + vrp_pkg::Z_OFFSET;
   assign zdiv = 18'({zs[16:0], 1'b0}) + zs[17:0];
   assign qs   = div_neg_ff ? -$signed(13'(div_q_ff)) : $signed(13'(div_q_ff));
   // angle magnitude / 100 and quotient / 360 by reciprocal multiplication
   assign q100 = 12'((39'(ang_mag_ff) * 39'(vrp_pkg::RECIP_100)) >> 26);
   assign q360 = 4'((24'(ang_q_ff) * 24'(vrp_pkg::RECIP_360)) >> 20);
   assign rdeg = (ang_neg_ff && ang_rem_ff != 9'd0) ? 9'd360 - ang_rem_ff : ang_rem_ff;

   always_comb begin
      state_in     = state_ff;
      vtx_in       = vtx_ff;
      step_in      = step_ff;
      ang_in       = ang_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      sine_in      = vrp_pkg::sine_fold(rdeg);
      sine_we      = 1'b0;
      acc_in       = acc_ff;
      m0_in        = m0_ff;
      m1_in        = m1_ff;
      m2_in        = m2_ff;
      sx_in        = sx_ff;
      ang_neg_in   = ang_neg_ff;
      ang_mag_in   = ang_mag_ff;
      ang_q_in     = ang_q_ff;
      ang_k_in     = ang_k_ff;
      ang_rem_in   = ang_rem_ff;
      free_in      = free_ff;
      div_load     = 1'b0;
      div_step     = 1'b0;
      div_mag      = '0;
      div_negv     = 1'b0;
      div_d        = '0;
      out_valid_in = out_valid_ff && !rsp_port.ready;
      out_idx_in   = out_idx_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_last_in  = out_last_ff;
      copy_we      = 1'b0;
      mix_we       = 1'b0;
      load_we      = 1'b0;
      mul_a        = 17'(cp);
      mul_b        = 17'(fc);
      wb_x         = m0_ff;
      wb_y         = m2_ff;
      wb_z         = rnd;
      if (!free_ff) begin
         wb_x = m2_ff;
         wb_y = m0_ff;
      end

      unique case (state_ff)
         vrp_pkg::ST_IDLE: begin
            if (req_acc) begin
               unique case (req_port.action)
                  vrp_pkg::ACT_REFRESH: begin
                     tx_in    = req_port.tilt_x;
                     ty_in    = req_port.tilt_y;
                     ang_in   = 2'd0;
                     state_in = vrp_pkg::ST_ANG_ABS;
                  end
                  vrp_pkg::ACT_TAP: begin
                     free_in = !free_ff;
                     if (free_ff) begin
                        vtx_in   = '0;
                        state_in = vrp_pkg::ST_COPY;
                     end
                  end
                  vrp_pkg::ACT_LOAD: begin
                     load_we = (32'(req_port.load_index) < NUM_VERTICES);
                  end
                  default: begin
                  end
               endcase
            end
         end
         vrp_pkg::ST_COPY: begin
            copy_we = 1'b1;
            if (last_vtx) begin
               state_in = vrp_pkg::ST_IDLE;
            end else begin
               vtx_in = vtx_ff + 1'b1;
            end
         end
         vrp_pkg::ST_ANG_ABS: begin
            ang_neg_in = ang_num[20];
            ang_mag_in = 19'(ang_num[20] ? -ang_num : ang_num);
            state_in   = vrp_pkg::ST_ANG_Q100;
         end
         vrp_pkg::ST_ANG_Q100: begin
            ang_q_in = q100;
            state_in = vrp_pkg::ST_ANG_Q360;
         end
         vrp_pkg::ST_ANG_Q360: begin
            ang_k_in = q360;
            state_in = vrp_pkg::ST_ANG_REM;
         end
         vrp_pkg::ST_ANG_REM: begin
            ang_rem_in = 9'(ang_q_ff - 12'(ang_k_ff) * 12'd360);
            state_in   = vrp_pkg::ST_ANG_LUT;
         end
         vrp_pkg::ST_ANG_LUT: begin
            sine_we = 1'b1;
            if (ang_ff == 2'd3) begin
               vtx_in   = '0;
               step_in  = '0;
               state_in = vrp_pkg::ST_MIX;
            end else begin
               ang_in   = ang_ff + 2'd1;
               state_in = vrp_pkg::ST_ANG_ABS;
            end
         end
         vrp_pkg::ST_MIX: begin
            unique case (step_ff)
               3'd0: begin mul_a = 17'(cp);    mul_b = 17'(fc);   end
               3'd1: begin mul_a = 17'(cq);    mul_b = -17'(fs);  end
               3'd2: begin mul_a = 17'(cp);    mul_b = 17'(fs);   end
               3'd3: begin mul_a = 17'(cq);    mul_b = 17'(fc);   end
               3'd4: begin mul_a = 17'(cr);    mul_b = 17'(fc2);  end
               3'd5: begin mul_a = 17'(m1_ff); mul_b = -17'(fs2); end
               3'd6: begin mul_a = 17'(cr);    mul_b = 17'(fs2);  end
               default: begin mul_a = 17'(m1_ff); mul_b = 17'(fc2); end
            endcase
            acc_in  = prod;
            step_in = step_ff + 3'd1;
            unique case (step_ff)
               3'd1: m0_in = rnd;
               3'd3: m1_in = rnd;
               3'd5: m2_in = rnd;
               default: begin
               end
            endcase
            if (step_ff == 3'd7) begin
               mix_we = 1'b1;
               if (32'(vtx_ff) < EMIT_COUNT) begin
                  state_in = vrp_pkg::ST_PX_LOAD;
               end else if (last_vtx) begin
                  state_in = vrp_pkg::ST_IDLE;
               end else begin
                  vtx_in = vtx_ff + 1'b1;
               end
            end
         end
         vrp_pkg::ST_PX_LOAD: begin
            mul_a    = 17'(cur_x_ff[vtx_ff]);
            mul_b    = SIZE_W;
            div_load = 1'b1;
            div_negv = prod[33];
            div_mag  = 27'(prod_mag_s);
            div_d    = zdiv;
            state_in = vrp_pkg::ST_PX_DIV;
         end
         vrp_pkg::ST_PX_DIV: begin
            div_step = 1'b1;
            if (div_cnt_ff == 4'(vrp_pkg::DIV_STEPS - 1)) state_in = vrp_pkg::ST_PY_LOAD;
         end
         vrp_pkg::ST_PY_LOAD: begin
            sx_in    = screen_sat(qs + HALF_W);
            mul_a    = 17'(cur_y_ff[vtx_ff]);
            mul_b    = SIZE_H;
            div_load = 1'b1;
            div_negv = prod[33];
            div_mag  = 27'(prod_mag_s);
            div_d    = zdiv;
            state_in = vrp_pkg::ST_PY_DIV;
         end
         vrp_pkg::ST_PY_DIV: begin
            div_step = 1'b1;
            if (div_cnt_ff == 4'(vrp_pkg::DIV_STEPS - 1)) state_in = vrp_pkg::ST_EMIT;
         end
         vrp_pkg::ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_idx_in   = 3'(vtx_ff);
               out_x_in     = sx_ff;
               out_y_in     = screen_sat(qs + HALF_H);
               out_last_in  = (32'(vtx_ff) == EMIT_COUNT - 1);
               step_in      = '0;
               if (last_vtx) begin
                  state_in = vrp_pkg::ST_IDLE;
               end else begin
                  vtx_in   = vtx_ff + 1'b1;
                  state_in = vrp_pkg::ST_MIX;
               end
            end
         end
         default: state_in = vrp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vrp_pkg::ST_IDLE;
         free_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         vtx_ff       <= '0;
         step_ff      <= '0;
         ang_ff       <= '0;
         cos_a_ff     <= vrp_pkg::RST_COS;
         sin_a_ff     <= vrp_pkg::RST_SIN;
         cos_b_ff     <= vrp_pkg::RST_COS;
         sin_b_ff     <= vrp_pkg::RST_SIN;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         out_valid_ff <= out_valid_in;
         vtx_ff       <= vtx_in;
         step_ff      <= step_in;
         ang_ff       <= ang_in;
         if (csr_port.valid && csr_port.ready) begin
            unique case (csr_port.index)
               vrp_pkg::CSR_COS_A: cos_a_ff <= csr_port.data;
               vrp_pkg::CSR_SIN_A: sin_a_ff <= csr_port.data;
               vrp_pkg::CSR_COS_B: cos_b_ff <= csr_port.data;
               default:            sin_b_ff <= csr_port.data;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      acc_ff      <= acc_in;
      m0_ff       <= m0_in;
      m1_ff       <= m1_in;
      m2_ff       <= m2_in;
      sx_ff       <= sx_in;
      ang_neg_ff  <= ang_neg_in;
      ang_mag_ff  <= ang_mag_in;
      ang_q_ff    <= ang_q_in;
      ang_k_ff    <= ang_k_in;
      ang_rem_ff  <= ang_rem_in;
      out_idx_ff  <= out_idx_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
      if (sine_we) sine_ff[ang_ff] <= sine_in;
   end

   // restoring divider, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (div_load) begin
         div_rem_ff <= 30'(div_mag);
         div_ds_ff  <= 30'(div_d) << (vrp_pkg::DIV_STEPS - 1);
         div_q_ff   <= '0;
         div_cnt_ff <= '0;
         div_neg_ff <= div_negv;
      end else if (div_step) begin
         if (div_rem_ff >= div_ds_ff) begin
            div_rem_ff <= div_rem_ff - div_ds_ff;
            div_q_ff   <= {div_q_ff[10:0], 1'b1};
         end else begin
            div_q_ff   <= {div_q_ff[10:0], 1'b0};
         end
         div_ds_ff  <= div_ds_ff >> 1;
         div_cnt_ff <= div_cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         orig_x[VW'(req_port.load_index)] <= req_port.load_x;
         orig_y[VW'(req_port.load_index)] <= req_port.load_y;
         orig_z[VW'(req_port.load_index)] <= req_port.load_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VERTICES; i++) begin
            cur_x_ff[i] <= '0;
            cur_y_ff[i] <= '0;
            cur_z_ff[i] <= '0;
         end
      end else if (copy_we) begin
         cur_x_ff[vtx_ff] <= orig_x[vtx_ff];
         cur_y_ff[vtx_ff] <= orig_y[vtx_ff];
         cur_z_ff[vtx_ff] <= orig_z[vtx_ff];
      end else if (mix_we) begin
         cur_x_ff[vtx_ff] <= wb_x;
         cur_y_ff[vtx_ff] <= wb_y;
         cur_z_ff[vtx_ff] <= wb_z;
      end
   end

endmodule

// ----- tb/tb_vertex_rotate_project.sv -----
// tb_vertex_rotate_project: checks rotation and projection results against a local predictor
`timescale 1ns / 1ps

module tb_vertex_rotate_project;

   typedef struct {
      logic [1:0]         action;
      logic signed [15:0] tilt_x;
      logic signed [15:0] tilt_y;
      logic [2:0]         load_index;
      logic signed [15:0] load_x;
      logic signed [15:0] load_y;
      logic signed [15:0] load_z;
   } cmd_type;

   typedef struct {
      logic [2:0]        point_index;
      logic signed [9:0] screen_x;
      logic signed [9:0] screen_y;
      logic              last_point;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vrp_req_if req_port();
   vrp_rsp_if rsp_port();
   vrp_csr_if csr_port();

   vertex_rotate_project u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port.sink),
      .rsp_port (rsp_port.source),
      .csr_port (csr_port.sink)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   cmd_type   cmd_queue[$];
   point_type point_queue[$];
   int     error_count = 0;
   int     cycle_count = 0;
   int     send_idle_pct = 0;
   int     recv_stall_pct = 0;
   bit     req_taken = 1'b0;

   // predictor state
   int  orig_vtx[8][3];
   int  cur_vtx[8][3];
   bit  in_free_mode;
   int  spin_ca, spin_sa, spin_cb, spin_sb;

   int  sine_tab[91] = '{
      0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126, 5690, 6252, 6813, 7371, 7927,
      8481, 9032, 9580, 10126, 10668, 11207, 11743, 12275, 12803, 13328, 13848, 14364, 14876,
      15383, 15886, 16383, 16876, 17364, 17846, 18323, 18794, 19260, 19720, 20173, 20621,
      21062, 21497, 21925, 22347, 22762, 23170, 23571, 23964, 24351, 24730, 25101, 25465,
      25821, 26169, 26509, 26841, 27165, 27481, 27788, 28087, 28377, 28659, 28932, 29196,
      29451, 29697, 29934, 30162, 30381, 30591, 30791, 30982, 31163, 31335, 31498, 31650,
      31794, 31927, 32051, 32165, 32269, 32364, 32448, 32523, 32587, 32642, 32687, 32722,
      32747, 32762, 32767};

   function automatic int sine_of_deg(int a);
      int r;
      r = a % 360;
      if (r < 0) r += 360;
      if (r < 90) return sine_tab[r];
      if (r < 180) return sine_tab[180 - r];
      if (r < 270) return -sine_tab[r - 180];
      return -sine_tab[360 - r];
   endfunction

   function automatic int rotate_term(int a, int ca, int b, int cb);
      longint t, q;
      t = longint'(a) * ca + longint'(b) * cb + 16384;
      q = (t >= 0) ? t / 32768 : -((-t + 32767) / 32768);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return int'(q);
   endfunction

   function automatic logic signed [9:0] screen_coord(int v, int z);
      longint p;
      p = (240 * longint'(v)) / (3 * (longint'(z) + 49152)) + 120;
      if (p > 511) p = 511;
      if (p < -512) p = -512;
      return 10'(p);
   endfunction

   task automatic predict_points(cmd_type c);
      int s1, c1, s2, c2, ox, oy, oz, zt;
      point_type p;
      if (c.action == vrp_pkg::ACT_LOAD) begin
         orig_vtx[c.load_index] = '{c.load_x, c.load_y, c.load_z};
      end else if (c.action == vrp_pkg::ACT_TAP) begin
         in_free_mode = !in_free_mode;
         if (!in_free_mode) cur_vtx = orig_vtx;
      end else if (c.action == vrp_pkg::ACT_REFRESH) begin
         s1 = sine_of_deg((-9 * int'(c.tilt_x)) / 100);
         c1 = sine_of_deg((9000 - 9 * int'(c.tilt_x)) / 100);
         s2 = sine_of_deg((9 * int'(c.tilt_y)) / 100);
         c2 = sine_of_deg((9000 + 9 * int'(c.tilt_y)) / 100);
         for (int i = 0; i < 8; i++) begin
            if (in_free_mode) begin
               ox = cur_vtx[i][0];
               oz = cur_vtx[i][2];
               cur_vtx[i][0] = rotate_term(ox, spin_ca, oz, -spin_sa);
               cur_vtx[i][2] = rotate_term(ox, spin_sa, oz, spin_ca);
               oy = cur_vtx[i][1];
               oz = cur_vtx[i][2];
               cur_vtx[i][1] = rotate_term(oy, spin_cb, oz, -spin_sb);
               cur_vtx[i][2] = rotate_term(oy, spin_sb, oz, spin_cb);
            end else begin
               cur_vtx[i][1] = rotate_term(orig_vtx[i][1], c2, orig_vtx[i][2], -s2);
               zt = rotate_term(orig_vtx[i][1], s2, orig_vtx[i][2], c2);
               cur_vtx[i][0] = rotate_term(orig_vtx[i][0], c1, zt, -s1);
               cur_vtx[i][2] = rotate_term(orig_vtx[i][0], s1, zt, c1);
            end
            p.point_index = 3'(i);
            p.screen_x = screen_coord(cur_vtx[i][0], cur_vtx[i][2]);
            p.screen_y = screen_coord(cur_vtx[i][1], cur_vtx[i][2]);
            p.last_point = (i == 7);
            point_queue.push_back(p);
         end
      end
   endtask

   task automatic report_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // driver
   initial begin
      req_port.valid = 1'b0;
      req_port.action = vrp_pkg::ACT_REFRESH;
      req_port.tilt_x = '0;
      req_port.tilt_y = '0;
      req_port.load_index = '0;
      req_port.load_x = '0;
      req_port.load_y = '0;
      req_port.load_z = '0;
      rsp_port.ready = 1'b0;
      csr_port.valid = 1'b0;
      csr_port.index = vrp_pkg::CSR_COS_A;
      csr_port.data = '0;
   end

   // word taken at the last rising edge
   always @(posedge clock) begin
      req_taken <= req_port.valid && req_port.ready;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_port.valid <= 1'b0;
      end else if (!req_port.valid || req_taken) begin
         if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_port.valid <= 1'b1;
            req_port.action <= cmd_queue[0].action;
            req_port.tilt_x <= cmd_queue[0].tilt_x;
            req_port.tilt_y <= cmd_queue[0].tilt_y;
            req_port.load_index <= cmd_queue[0].load_index;
            req_port.load_x <= cmd_queue[0].load_x;
            req_port.load_y <= cmd_queue[0].load_y;
            req_port.load_z <= cmd_queue[0].load_z;
            void'(cmd_queue.pop_front());
         end else begin
            req_port.valid <= 1'b0;
         end
      end
      rsp_port.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      cmd_type   c;
      point_type exp_pt;
      cycle_count <= cycle_count + 1;
      if (!reset && req_port.valid && req_port.ready) begin
         c.action = req_port.action;
         c.tilt_x = req_port.tilt_x;
         c.tilt_y = req_port.tilt_y;
         c.load_index = req_port.load_index;
         c.load_x = req_port.load_x;
         c.load_y = req_port.load_y;
         c.load_z = req_port.load_z;
         predict_points(c);
      end
      if (!reset && rsp_port.valid && rsp_port.ready) begin
         if (point_queue.size() == 0) begin
            report_mismatch("unexpected point");
         end else begin
            exp_pt = point_queue.pop_front();
            if (rsp_port.point_index !== exp_pt.point_index)
               report_mismatch($sformatf("point_index %0d exp %0d",
                  rsp_port.point_index, exp_pt.point_index));
            if (rsp_port.screen_x !== exp_pt.screen_x)
               report_mismatch($sformatf("screen_x %0d exp %0d pt %0d",
                  rsp_port.screen_x, exp_pt.screen_x, exp_pt.point_index));
            if (rsp_port.screen_y !== exp_pt.screen_y)
               report_mismatch($sformatf("screen_y %0d exp %0d pt %0d",
                  rsp_port.screen_y, exp_pt.screen_y, exp_pt.point_index));
            if (rsp_port.last_point !== exp_pt.last_point)
               report_mismatch($sformatf("last_point %0b exp %0b",
                  rsp_port.last_point, exp_pt.last_point));
         end
      end
   end

   task automatic add_cmd(logic [1:0] act, logic signed [15:0] tx, logic signed [15:0] ty,
                          logic [2:0] li, logic signed [15:0] lx, logic signed [15:0] ly,
                          logic signed [15:0] lz);
      cmd_type c;
      c = '{act, tx, ty, li, lx, ly, lz};
      cmd_queue.push_back(c);
   endtask

   task automatic add_random_cmd();
      int r;
      r = $urandom_range(99);
      if (r < 45)
         add_cmd(vrp_pkg::ACT_REFRESH, 16'($urandom), 16'($urandom), 3'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom));
      else if (r < 60)
         add_cmd(vrp_pkg::ACT_TAP, 16'($urandom), 16'($urandom), 3'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom));
      else if (r < 95)
         add_cmd(vrp_pkg::ACT_LOAD, 16'($urandom), 16'($urandom), 3'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom));
      else
         add_cmd(vrp_pkg::ACT_NOP, 16'($urandom), 16'($urandom), 3'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic drain_and_settle();
      while (cmd_queue.size() != 0 || req_port.valid || point_queue.size() != 0)
         @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   task automatic write_spin(logic [1:0] idx, logic signed [15:0] value);
      @(negedge clock);
      csr_port.valid <= 1'b1;
      csr_port.index <= idx;
      csr_port.data <= value;
      @(posedge clock);
      while (!csr_port.ready) @(posedge clock);
      case (idx)
         vrp_pkg::CSR_COS_A: spin_ca = value;
         vrp_pkg::CSR_SIN_A: spin_sa = value;
         vrp_pkg::CSR_COS_B: spin_cb = value;
         default: spin_sb = value;
      endcase
      @(negedge clock);
      csr_port.valid <= 1'b0;
   endtask

   // stimulus
   initial begin
      logic signed [15:0] spin_set[4][4];
      int                 idle_set[4][2];
      in_free_mode = 1'b0;
      spin_ca = vrp_pkg::RST_COS;
      spin_sa = vrp_pkg::RST_SIN;
      spin_cb = vrp_pkg::RST_COS;
      spin_sb = vrp_pkg::RST_SIN;
      foreach (cur_vtx[i, j]) begin
         cur_vtx[i][j] = 0;
         orig_vtx[i][j] = 0;
      end
      spin_set = '{'{16'sd32767, 16'sd0, -16'sd32768, 16'sd32767},
                   '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd32768},
                   '{16'sd23170, -16'sd23170, 16'sd30000, 16'sd12000},
                   '{16'sd32758, 16'sd572, 16'sd32758, 16'sd572}};
      idle_set = '{'{0, 0}, '{59, 0}, '{0, 59}, '{7, 7}};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: fill all originals with extremes, then every action
      for (int i = 0; i < 8; i++)
         add_cmd(vrp_pkg::ACT_LOAD, 0, 0, 3'(i), (i[0] ? 16'sh7fff : 16'sh8000),
                 (i[1] ? 16'sh7fff : 16'sh8000), (i[2] ? 16'sh7fff : 16'sh8000));
      add_cmd(vrp_pkg::ACT_REFRESH, 0, 0, 0, 0, 0, 0);
      add_cmd(vrp_pkg::ACT_REFRESH, 16'sh7fff, 16'sh8000, 0, 0, 0, 0);
      add_cmd(vrp_pkg::ACT_REFRESH, 16'sh8000, 16'sh7fff, 0, 0, 0, 0);
      add_cmd(vrp_pkg::ACT_REFRESH, 16'sd1000, -16'sd1000, 0, 0, 0, 0);
      add_cmd(vrp_pkg::ACT_NOP, 16'sh7fff, 16'sh7fff, 3'd7, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      add_cmd(vrp_pkg::ACT_TAP, 0, 0, 0, 0, 0, 0);
      add_cmd(vrp_pkg::ACT_REFRESH, 0, 0, 0, 0, 0, 0);
      add_cmd(vrp_pkg::ACT_TAP, 0, 0, 0, 0, 0, 0);
      add_cmd(vrp_pkg::ACT_TAP, 0, 0, 0, 0, 0, 0);
      add_cmd(vrp_pkg::ACT_REFRESH, 0, 0, 0, 0, 0, 0);
      add_cmd(vrp_pkg::ACT_LOAD, 0, 0, 3'd3, 16'sd0, 16'sd0, 16'sd0);
      add_cmd(vrp_pkg::ACT_REFRESH, -16'sd500, 16'sd2500, 0, 0, 0, 0);
      drain_and_settle();

      for (int ph = 0; ph < 4; ph++) begin
         for (int k = 0; k < 4; k++)
            write_spin(2'(k), spin_set[ph][k]);
         send_idle_pct = idle_set[ph][0];
         recv_stall_pct = idle_set[ph][1];
         for (int n = 0; n < 40; n++) add_random_cmd();
         drain_and_settle();
      end

      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   always @(posedge clock) begin
      if (cycle_count > 2000000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule
